FILE: sv/itr_pkg.sv
package itr_pkg;

  // Upper bound on message length, also the width limit of the length field
  localparam int unsigned MAX_LEN = 4095;
  localparam int unsigned LEN_W   = 12;

  // Job queue between the classifier and the result streamer
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  // Register defaults
  localparam logic [LEN_W-1:0] MAX_LEN_RST = 12'd4095;
  localparam logic [2:0]       TIMEOUT_RST = 3'd5;

  // Configuration register indexes
  localparam logic CFG_MAX_LEN = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // Frame type nibble
  localparam logic [3:0] TYPE_SINGLE = 4'h0;
  localparam logic [3:0] TYPE_FIRST  = 4'h1;
  localparam logic [3:0] TYPE_CONSEC = 4'h2;

  // Input action codes
  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef enum logic [2:0] {
    KIND_BYTE    = 3'd0,
    KIND_FC      = 3'd1,
    KIND_ERR     = 3'd2,
    KIND_TIMEOUT = 3'd3,
    KIND_EMPTY   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_BAD_TYPE  = 2'd0,
    ERR_SEQUENCE  = 2'd1,
    ERR_TOO_LARGE = 2'd2,
    ERR_STRAY     = 2'd3
  } err_t;

  // One item's worth of results: optional head result, up to seven payload
  // bytes, and an optional trailing empty-message marker.
  typedef struct packed {
    logic             has_head;
    kind_t            head_kind;
    err_t             head_err;
    logic [2:0]       nbytes;
    logic [6:0][7:0]  data;
    logic             mark_last;
    logic             tail_empty;
  } job_t;

endpackage

FILE: sv/itr_fifo.sv
module itr_fifo
  import itr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic head_valid,
  output job_t head_job,
  input  logic pop
);

  job_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_AW:0]     count_r;
  logic                 do_push;
  logic                 do_pop;

  assign full       = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: sv/itr_front.sv
module itr_front
  import itr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             accept,
  input  logic             action,
  input  logic [7:0]       byte0,
  input  logic [7:0]       byte1,
  input  logic [7:0]       byte2,
  input  logic [7:0]       byte3,
  input  logic [7:0]       byte4,
  input  logic [7:0]       byte5,
  input  logic [7:0]       byte6,
  input  logic [7:0]       byte7,
  output logic             push,
  output job_t             job
);

  logic [LEN_W-1:0] max_len_r;
  logic [2:0]       timeout_r;

  logic [LEN_W-1:0] exp_len_r, exp_len_nxt;
  logic [LEN_W-1:0] rcv_cnt_r, rcv_cnt_nxt;
  logic [3:0]       seq_r, seq_nxt;
  logic             recv_r, recv_nxt;
  logic [2:0]       idle_r, idle_nxt;

  logic [LEN_W-1:0] lim;
  logic [2:0]       tmo_eff;
  logic [2:0]       idle_inc;
  logic [3:0]       ftype;
  logic [3:0]       low;
  logic [LEN_W-1:0] ff_len;
  logic [LEN_W-1:0] rem;
  logic [2:0]       take;
  logic             done;

  assign lim      = (max_len_r < LEN_W'(MAX_LEN)) ? max_len_r : LEN_W'(MAX_LEN);
  assign tmo_eff  = (timeout_r == 3'd0) ? 3'd1 : timeout_r;
  assign idle_inc = (idle_r != 3'd7) ? idle_r + 3'd1 : idle_r;
  assign ftype    = byte0[7:4];
  assign low      = byte0[3:0];
  assign ff_len   = {low, byte1};
  assign rem      = (exp_len_r > rcv_cnt_r) ? exp_len_r - rcv_cnt_r : '0;
  assign take     = (rem < LEN_W'(7)) ? rem[2:0] : 3'd7;
  assign done     = (rem <= LEN_W'(7));

  // classify the item, update reassembly state and build its job
  always_comb begin
    exp_len_nxt = exp_len_r;
    rcv_cnt_nxt = rcv_cnt_r;
    seq_nxt     = seq_r;
    recv_nxt    = recv_r;
    idle_nxt    = idle_r;
    job         = '0;
    job.head_kind = KIND_BYTE;
    job.head_err  = ERR_BAD_TYPE;

    if (accept) begin
      if (action == ACT_TICK) begin
        if (recv_r) begin
          idle_nxt = idle_inc;
          if (idle_inc >= tmo_eff) begin
            job.has_head  = 1'b1;
            job.head_kind = KIND_TIMEOUT;
            recv_nxt      = 1'b0;
            exp_len_nxt   = '0;
            rcv_cnt_nxt   = '0;
            seq_nxt       = '0;
            idle_nxt      = '0;
          end
        end
      end else begin
        idle_nxt = '0;
        unique case (ftype)
          TYPE_SINGLE: begin
            recv_nxt    = 1'b0;
            exp_len_nxt = '0;
            rcv_cnt_nxt = '0;
            seq_nxt     = '0;
            job.data    = {byte7, byte6, byte5, byte4, byte3, byte2, byte1};
            if (low > 4'd7) begin
              job.has_head  = 1'b1;
              job.head_kind = KIND_ERR;
              job.head_err  = ERR_BAD_TYPE;
            end else if (LEN_W'(low) > lim) begin
              job.has_head  = 1'b1;
              job.head_kind = KIND_ERR;
              job.head_err  = ERR_TOO_LARGE;
            end else if (low == 4'd0) begin
              job.has_head  = 1'b1;
              job.head_kind = KIND_EMPTY;
            end else begin
              job.nbytes    = low[2:0];
              job.mark_last = 1'b1;
            end
          end
          TYPE_FIRST: begin
            recv_nxt    = 1'b0;
            exp_len_nxt = '0;
            rcv_cnt_nxt = '0;
            seq_nxt     = '0;
            job.data    = {8'h00, byte7, byte6, byte5, byte4, byte3, byte2};
            job.has_head = 1'b1;
            if (ff_len > lim) begin
              job.head_kind = KIND_ERR;
              job.head_err  = ERR_TOO_LARGE;
            end else begin
              job.head_kind = KIND_FC;
              if (ff_len == '0) begin
                job.tail_empty = 1'b1;
              end else begin
                job.nbytes    = (ff_len < LEN_W'(6)) ? ff_len[2:0] : 3'd6;
                job.mark_last = (ff_len <= LEN_W'(6));
                if (ff_len > LEN_W'(6)) begin
                  recv_nxt    = 1'b1;
                  exp_len_nxt = ff_len;
                  rcv_cnt_nxt = LEN_W'(6);
                end
              end
            end
          end
          TYPE_CONSEC: begin
            job.data = {byte7, byte6, byte5, byte4, byte3, byte2, byte1};
            if (!recv_r) begin
              job.has_head  = 1'b1;
              job.head_kind = KIND_ERR;
              job.head_err  = ERR_STRAY;
            end else if (low != seq_r + 4'd1) begin
              job.has_head  = 1'b1;
              job.head_kind = KIND_ERR;
              job.head_err  = ERR_SEQUENCE;
              recv_nxt      = 1'b0;
              exp_len_nxt   = '0;
              rcv_cnt_nxt   = '0;
              seq_nxt       = '0;
            end else begin
              job.nbytes    = take;
              job.mark_last = done;
              seq_nxt       = low;
              rcv_cnt_nxt   = rcv_cnt_r + LEN_W'(take);
              if (done) begin
                recv_nxt    = 1'b0;
                exp_len_nxt = '0;
                rcv_cnt_nxt = '0;
                seq_nxt     = '0;
              end
            end
          end
          default: begin
            // flow control or undefined type
            job.has_head  = 1'b1;
            job.head_kind = KIND_ERR;
            job.head_err  = ERR_BAD_TYPE;
            recv_nxt      = 1'b0;
            exp_len_nxt   = '0;
            rcv_cnt_nxt   = '0;
            seq_nxt       = '0;
          end
        endcase
      end
    end
  end

  // only items that produce results enter the queue
  assign push = accept && (job.has_head || (job.nbytes != 3'd0) || job.tail_empty);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MAX_LEN) begin
        max_len_r <= cfg_wdata;
      end else begin
        timeout_r <= cfg_wdata[2:0];
      end
    end
  end

  // reassembly state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= '0;
      rcv_cnt_r <= '0;
      seq_r     <= '0;
      recv_r    <= 1'b0;
      idle_r    <= '0;
    end else begin
      exp_len_r <= exp_len_nxt;
      rcv_cnt_r <= rcv_cnt_nxt;
      seq_r     <= seq_nxt;
      recv_r    <= recv_nxt;
      idle_r    <= idle_nxt;
    end
  end

endmodule

FILE: sv/itr_back.sv
module itr_back
  import itr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output kind_t      out_kind,
  output logic [7:0] out_payload_byte,
  output err_t       out_error_code,
  output logic       out_last_of_message,
  output logic       out_last_of_item
);

  logic       out_valid_r;
  kind_t      kind_r;
  logic [7:0] byte_r;
  err_t       err_r;
  logic       last_msg_r;
  logic       last_item_r;
  logic [2:0] pos_r;

  logic       load;
  logic [3:0] total;
  logic       last;
  logic [2:0] idx;
  logic       in_head;
  logic       in_bytes;
  kind_t      kind_nxt;
  logic [7:0] byte_nxt;
  err_t       err_nxt;
  logic       last_msg_nxt;

  assign load    = job_valid && (!out_valid_r || out_ready);
  assign total   = 4'(job.has_head) + 4'(job.nbytes) + 4'(job.tail_empty);
  assign last    = (4'(pos_r) + 4'd1 == total);
  assign job_pop = load && last;
  assign in_head = job.has_head && (pos_r == 3'd0);
  assign idx     = pos_r - 3'(job.has_head);
  assign in_bytes = !in_head && (idx < job.nbytes);

  // pick the result at the current position of the head job
  always_comb begin
    kind_nxt     = KIND_EMPTY;
    byte_nxt     = 8'h00;
    err_nxt      = ERR_BAD_TYPE;
    last_msg_nxt = 1'b0;
    if (in_head) begin
      kind_nxt = job.head_kind;
      if (job.head_kind == KIND_ERR) begin
        err_nxt = job.head_err;
      end
    end else if (in_bytes) begin
      kind_nxt     = KIND_BYTE;
      byte_nxt     = job.data[idx];
      last_msg_nxt = job.mark_last && (idx + 3'd1 == job.nbytes);
    end
  end

  // output register; one result per cycle while out_ready is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      pos_r       <= last ? 3'd0 : pos_r + 3'd1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r      <= kind_nxt;
      byte_r      <= byte_nxt;
      err_r       <= err_nxt;
      last_msg_r  <= last_msg_nxt;
      last_item_r <= last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = kind_r;
  assign out_payload_byte    = byte_r;
  assign out_error_code      = err_r;
  assign out_last_of_message = last_msg_r;
  assign out_last_of_item    = last_item_r;

endmodule

FILE: sv/iso_tp_receive_reassembler.sv
// Transport-layer receive reassembler for classic 8-byte CAN frames.
//
// Input channel (in_valid/in_ready): one item is either a received frame
// (in_action = 0, bytes in in_byte0..in_byte7) or an idle time tick
// (in_action = 1, bytes ignored). Output channel (out_valid/out_ready): the
// results of each item come out in order; an item gives zero to seven
// results, out_last_of_item marks the final one. Payload bytes come out in
// message order.
// Configuration: cfg_we/cfg_index/cfg_wdata, index 0 = max message length,
// index 1 = timeout in ticks; write only while the block is idle.
//
// Path: the first result of an item passes through the job queue and then
// the output register before it shows on out_valid.
// Throughput: the classifier takes an item every cycle while the queue has
// room; the result streamer emits one result per cycle while out_ready is
// high, and a full frame gives up to 7 results. A
// four-entry job queue between classifier and streamer absorbs bursts.
// Reset (rst_n low, synchronous) empties the queue, drops any message in
// progress and restores the register defaults (4095 bytes, 5 ticks).
// When the receiver holds out_ready low, the current result stays put, the
// queue fills, and in_ready drops once it is full.
module iso_tp_receive_reassembler
  import itr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [7:0]       in_byte0,
  input  logic [7:0]       in_byte1,
  input  logic [7:0]       in_byte2,
  input  logic [7:0]       in_byte3,
  input  logic [7:0]       in_byte4,
  input  logic [7:0]       in_byte5,
  input  logic [7:0]       in_byte6,
  input  logic [7:0]       in_byte7,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_payload_byte,
  output logic [1:0]       out_error_code,
  output logic             out_last_of_message,
  output logic             out_last_of_item
);

  logic  fifo_full;
  logic  push;
  job_t  push_job;
  logic  head_valid;
  job_t  head_job;
  logic  pop;
  kind_t kind_w;
  err_t  err_w;

  assign in_ready = !fifo_full;

  // classifier
  itr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (in_valid && in_ready),
    .action    (in_action),
    .byte0     (in_byte0),
    .byte1     (in_byte1),
    .byte2     (in_byte2),
    .byte3     (in_byte3),
    .byte4     (in_byte4),
    .byte5     (in_byte5),
    .byte6     (in_byte6),
    .byte7     (in_byte7),
    .push      (push),
    .job       (push_job)
  );

  // job queue
  itr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (fifo_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  // result streamer
  itr_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_valid           (head_valid),
    .job                 (head_job),
    .job_pop             (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (kind_w),
    .out_payload_byte    (out_payload_byte),
    .out_error_code      (err_w),
    .out_last_of_message (out_last_of_message),
    .out_last_of_item    (out_last_of_item)
  );

  assign out_kind       = kind_w;
  assign out_error_code = err_w;

  // the final byte of a message always closes its item
  a_last_msg_closes_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_message |-> out_last_of_item && out_kind == KIND_BYTE)
    else $error("last_of_message without last_of_item");

  // payload byte is zero on non-byte results
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BYTE |-> out_payload_byte == 8'h00)
    else $error("payload byte set on non-byte result");

  // error code is zero unless the result is an error
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_ERR |-> out_error_code == ERR_BAD_TYPE)
    else $error("error code set on non-error result");

  // the queue never takes a job while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_full |-> !(in_valid && in_ready))
    else $error("item accepted with full job queue");

endmodule
